// File: design/ptom_pkg.sv
// Package for the price-time order matcher.
// Holds shared constants, result codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package ptom_pkg;

	// default table depth
	localparam int BOOK_DEPTH_DEF = 16;

	// trades per matching pass
	localparam int MAX_RESULTS = 15;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	// field widths
	localparam int OPW  = 2;
	localparam int TRDW = 31;
	localparam int SYMW = 16;
	localparam int PXW  = 32;
	localparam int QTYW = 31;
	localparam int ARRW = 32;
	localparam int STW  = 3;

	// input opcodes
	localparam logic [OPW-1:0] OP_BUY    = 2'd0;
	localparam logic [OPW-1:0] OP_SELL   = 2'd1;
	localparam logic [OPW-1:0] OP_MATCH  = 2'd2;
	localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

	// result status codes
	localparam logic [STW-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [STW-1:0] ST_FULL     = 3'd1;
	localparam logic [STW-1:0] ST_ZERO     = 3'd2;
	localparam logic [STW-1:0] ST_TRADE    = 3'd3;
	localparam logic [STW-1:0] ST_NO_TRADE = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic cap;       // latch input beat
		logic add_do;    // perform add and emit its status
		logic scan_buy;  // one buy scan step
		logic scan_sell; // one sell scan step
		logic buy_take;  // best buy becomes active buy
		logic trade;     // execute trade with best sell
		logic fin;       // emit final result of pass
	} ptom_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic best_v;     // scan found a candidate
		logic scan_last;  // scan index at last slot
		logic out_free;   // output register can load
		logic pend_v;     // a trade waits for its last flag
		logic pass_end;   // next trade reaches the trade limit
		logic buy_fill;   // next trade fills the active buy
	} ptom_sts_t;

endpackage

`default_nettype wire

// File: design/ptom_dp.sv
// Datapath of the order matcher: order table, scan compare, trade arithmetic, output register.
// Depends on ptom_pkg; driven by ptom_ctrl through ptom_cmd_t.
`default_nettype none

module ptom_dp import ptom_pkg::*; #(
	parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [OPW-1:0]   opcode,
	input  wire logic [TRDW-1:0]  trader,
	input  wire logic [SYMW-1:0]  symbol,
	input  wire logic [PXW-1:0]   price,
	input  wire logic [QTYW-1:0]  quantity,
	input  wire ptom_cmd_t        cmd,
	output ptom_sts_t             sts,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [STW-1:0]        status,
	output logic [TRDW-1:0]       buy_trader,
	output logic [TRDW-1:0]       sell_trader,
	output logic [SYMW-1:0]       trade_symbol,
	output logic [QTYW-1:0]       trade_quantity,
	output logic [PXW-1:0]        trade_price,
	output logic                  last
);

	localparam int IW = $clog2(BOOK_DEPTH);

	// latched input beat
	logic            op_sell_q;
	logic [TRDW-1:0] trd_q;
	logic [SYMW-1:0] sym_q;
	logic [PXW-1:0]  px_q;
	logic [QTYW-1:0] qty_q;

	// order table
	logic [BOOK_DEPTH-1:0] e_valid_q;
	logic [BOOK_DEPTH-1:0] e_sell_q;
	logic [BOOK_DEPTH-1:0] done_q;
	logic [TRDW-1:0]       e_trd_q [BOOK_DEPTH];
	logic [SYMW-1:0]       e_sym_q [BOOK_DEPTH];
	logic [PXW-1:0]        e_px_q  [BOOK_DEPTH];
	logic [QTYW-1:0]       e_rem_q [BOOK_DEPTH];
	logic [ARRW-1:0]       e_arr_q [BOOK_DEPTH];
	logic [ARRW-1:0]       arr_cnt_q;

	// scan state
	logic [IW-1:0]   idx_q;
	logic            best_v_q;
	logic [IW-1:0]   best_idx_q;
	logic [PXW-1:0]  best_px_q;
	logic [ARRW-1:0] best_arr_q;
	logic [TRDW-1:0] best_trd_q;
	logic [SYMW-1:0] best_sym_q;
	logic [QTYW-1:0] best_rem_q;

	// active buy
	logic [IW-1:0]   buy_idx_q;
	logic [TRDW-1:0] buy_trd_q;
	logic [SYMW-1:0] buy_sym_q;
	logic [PXW-1:0]  buy_px_q;
	logic [QTYW-1:0] buy_rem_q;
	logic [NW-1:0]   n_q;

	// trade waiting for its last flag
	logic            pend_v_q;
	logic [TRDW-1:0] pend_bt_q;
	logic [TRDW-1:0] pend_st_q;
	logic [SYMW-1:0] pend_sym_q;
	logic [QTYW-1:0] pend_qty_q;
	logic [PXW-1:0]  pend_px_q;

	logic out_v_q;

	// lowest free slot
	logic [IW-1:0] free_idx;
	logic          full;
	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
			if (!e_valid_q[i]) begin
				free_idx = IW'(i);
				full     = 1'b0;
			end
		end
	end

	logic [STW-1:0] add_st;
	assign add_st = (qty_q == '0) ? ST_ZERO : (full ? ST_FULL : ST_ACCEPTED);

	// candidate at scan index
	logic [PXW-1:0]  c_px;
	logic [ARRW-1:0] c_arr;
	logic            c_ok, c_better, take;
	assign c_px  = e_px_q[idx_q];
	assign c_arr = e_arr_q[idx_q];

	always_comb begin
		if (cmd.scan_sell) begin
			c_ok = e_valid_q[idx_q] && e_sell_q[idx_q] && (e_sym_q[idx_q] == buy_sym_q)
				&& (c_px <= buy_px_q);
		end else begin
			c_ok = e_valid_q[idx_q] && !e_sell_q[idx_q] && !done_q[idx_q];
		end
		if (c_px != best_px_q) begin
			c_better = cmd.scan_sell ? (c_px < best_px_q) : (c_px > best_px_q);
		end else begin
			c_better = c_arr < best_arr_q;
		end
	end
	assign take = c_ok && ((idx_q == '0) || !best_v_q || c_better);

	// trade arithmetic
	logic [QTYW-1:0] tq, b_new, s_new;
	assign tq    = (buy_rem_q < best_rem_q) ? buy_rem_q : best_rem_q;
	assign b_new = buy_rem_q - tq;
	assign s_new = best_rem_q - tq;

	logic out_free;
	assign out_free = !out_v_q || out_ready;

	always_comb begin
		sts.best_v    = best_v_q;
		sts.scan_last = (idx_q == IW'(BOOK_DEPTH - 1));
		sts.out_free  = out_free;
		sts.pend_v    = pend_v_q;
		sts.pass_end  = (n_q == NW'(MAX_RESULTS - 1));
		sts.buy_fill  = (b_new == '0);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_q <= '0;
			done_q    <= '0;
			arr_cnt_q <= '0;
			idx_q     <= '0;
			best_v_q  <= 1'b0;
			n_q       <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.cap) begin
				done_q   <= '0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.add_do && add_st == ST_ACCEPTED) begin
				e_valid_q[free_idx] <= 1'b1;
				arr_cnt_q           <= arr_cnt_q + 1'b1;
			end
			if (cmd.scan_buy || cmd.scan_sell) begin
				idx_q <= sts.scan_last ? '0 : idx_q + 1'b1;
				if (idx_q == '0) begin
					best_v_q <= c_ok;
				end else if (take) begin
					best_v_q <= 1'b1;
				end
			end
			if (cmd.buy_take) begin
				done_q[best_idx_q] <= 1'b1;
			end
			if (cmd.trade) begin
				n_q      <= n_q + 1'b1;
				pend_v_q <= 1'b1;
				if (b_new == '0) begin
					e_valid_q[buy_idx_q] <= 1'b0;
				end
				if (s_new == '0) begin
					e_valid_q[best_idx_q] <= 1'b0;
				end
			end
			if (cmd.fin) begin
				pend_v_q <= 1'b0;
			end
			// output register handshake; a load only comes when the register is free
			if (cmd.add_do || cmd.fin || (cmd.trade && pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_sell_q <= (opcode == OP_SELL);
			trd_q     <= trader;
			sym_q     <= symbol;
			px_q      <= price;
			qty_q     <= quantity;
		end
		if (cmd.add_do && add_st == ST_ACCEPTED) begin
			e_sell_q[free_idx] <= op_sell_q;
			e_trd_q[free_idx]  <= trd_q;
			e_sym_q[free_idx]  <= sym_q;
			e_px_q[free_idx]   <= px_q;
			e_rem_q[free_idx]  <= qty_q;
			e_arr_q[free_idx]  <= arr_cnt_q;
		end
		if ((cmd.scan_buy || cmd.scan_sell) && take) begin
			best_idx_q <= idx_q;
			best_px_q  <= c_px;
			best_arr_q <= c_arr;
			best_trd_q <= e_trd_q[idx_q];
			best_sym_q <= e_sym_q[idx_q];
			best_rem_q <= e_rem_q[idx_q];
		end
		if (cmd.buy_take) begin
			buy_idx_q <= best_idx_q;
			buy_trd_q <= best_trd_q;
			buy_sym_q <= best_sym_q;
			buy_px_q  <= best_px_q;
			buy_rem_q <= best_rem_q;
		end
		if (cmd.trade) begin
			buy_rem_q             <= b_new;
			e_rem_q[buy_idx_q]    <= b_new;
			e_rem_q[best_idx_q]   <= s_new;
			pend_bt_q  <= buy_trd_q;
			pend_st_q  <= best_trd_q;
			pend_sym_q <= best_sym_q;
			pend_qty_q <= tq;
			pend_px_q  <= best_px_q;
		end
		// output payload
		if (cmd.add_do) begin
			status         <= add_st;
			buy_trader     <= '0;
			sell_trader    <= '0;
			trade_symbol   <= '0;
			trade_quantity <= '0;
			trade_price    <= '0;
			last           <= 1'b1;
		end else if ((cmd.trade && pend_v_q) || (cmd.fin && pend_v_q)) begin
			status         <= ST_TRADE;
			buy_trader     <= pend_bt_q;
			sell_trader    <= pend_st_q;
			trade_symbol   <= pend_sym_q;
			trade_quantity <= pend_qty_q;
			trade_price    <= pend_px_q;
			last           <= cmd.fin;
		end else if (cmd.fin) begin
			status         <= ST_NO_TRADE;
			buy_trader     <= '0;
			sell_trader    <= '0;
			trade_symbol   <= '0;
			trade_quantity <= '0;
			trade_price    <= '0;
			last           <= 1'b1;
		end
	end

	assign out_valid = out_v_q;

endmodule

`default_nettype wire

// File: design/ptom_ctrl.sv
// Controller state machine of the order matcher: sequences adds, scans and trades.
// Depends on ptom_pkg; commands ptom_dp.
`default_nettype none

module ptom_ctrl import ptom_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [OPW-1:0] opcode,
	input  wire ptom_sts_t      sts,
	output ptom_cmd_t           cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ADD   = 7'b0000010,
		S_BSCAN = 7'b0000100,
		S_BEND  = 7'b0001000,
		S_SSCAN = 7'b0010000,
		S_SEND  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (opcode)
						OP_BUY, OP_SELL: state_d = S_ADD;
						OP_MATCH:        state_d = S_BSCAN;
						default:         state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				if (sts.out_free) begin
					cmd.add_do = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_BSCAN: begin
				cmd.scan_buy = 1'b1;
				if (sts.scan_last) begin
					state_d = S_BEND;
				end
			end
			S_BEND: begin
				if (sts.best_v) begin
					cmd.buy_take = 1'b1;
					state_d      = S_SSCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SSCAN: begin
				cmd.scan_sell = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SEND;
				end
			end
			S_SEND: begin
				if (!sts.best_v) begin
					state_d = S_BSCAN;
				end else if (!sts.pend_v || sts.out_free) begin
					cmd.trade = 1'b1;
					if (sts.pass_end) begin
						state_d = S_FIN;
					end else if (sts.buy_fill) begin
						state_d = S_BSCAN;
					end else begin
						state_d = S_SSCAN;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: design/price_time_order_matcher_core.sv
// Top level of the price-time priority order matcher.
// Depends on ptom_pkg; instantiates ptom_ctrl and ptom_dp.
//
// channel  | handshake             | beat fields
// ---------+-----------------------+-----------------------------------------------
// input    | in_valid / in_ready   | opcode, trader, symbol, price, quantity
// output   | out_valid / out_ready | status, buy_trader, sell_trader, trade_symbol,
//          |                       | trade_quantity, trade_price, last
//
// An add does capture, then table write and status into the output register.
// A match pass scans the table one slot per cycle, in buy searches and sell searches, with
// at most one trade per sell search, and ends in the finish state.
// One item is in work at a time; input is taken only in the idle state.
// A full output register stalls the controller; an earlier result stays held meanwhile.
// Reset clears the valid bits, arrival counter and all control state at once.
`default_nettype none

module price_time_order_matcher_core import ptom_pkg::*; #(
	parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [OPW-1:0]   opcode,
	input  wire logic [TRDW-1:0]  trader,
	input  wire logic [SYMW-1:0]  symbol,
	input  wire logic [PXW-1:0]   price,
	input  wire logic [QTYW-1:0]  quantity,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [STW-1:0]        status,
	output logic [TRDW-1:0]       buy_trader,
	output logic [TRDW-1:0]       sell_trader,
	output logic [SYMW-1:0]       trade_symbol,
	output logic [QTYW-1:0]       trade_quantity,
	output logic [PXW-1:0]        trade_price,
	output logic                  last
);

	ptom_cmd_t cmd;
	ptom_sts_t sts;

	ptom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptom_dp #(
		.BOOK_DEPTH (BOOK_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (opcode),
		.trader         (trader),
		.symbol         (symbol),
		.price          (price),
		.quantity       (quantity),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.status         (status),
		.buy_trader     (buy_trader),
		.sell_trader    (sell_trader),
		.trade_symbol   (trade_symbol),
		.trade_quantity (trade_quantity),
		.trade_price    (trade_price),
		.last           (last)
	);

endmodule

`default_nettype wire

// File: verif/price_time_order_matcher_core_tb.sv
// Self-checking testbench for price_time_order_matcher_core.
// Depends on ptom_pkg; predicts order-book adds and match-pass trades in SV and
// compares every output beat against the prediction.
`default_nettype none

module price_time_order_matcher_core_tb;
	import ptom_pkg::*;

	localparam int DEPTH = BOOK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [OPW-1:0]  op;
		logic [TRDW-1:0] trd;
		logic [SYMW-1:0] sym;
		logic [PXW-1:0]  px;
		logic [QTYW-1:0] qty;
	} order_beat_t;

	typedef struct packed {
		logic [STW-1:0]  st;
		logic [TRDW-1:0] bt;
		logic [TRDW-1:0] sl;
		logic [SYMW-1:0] sym;
		logic [QTYW-1:0] qty;
		logic [PXW-1:0]  px;
		logic            lst;
	} fill_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OPW-1:0] opcode = '0;
	logic [TRDW-1:0] trader = '0;
	logic [SYMW-1:0] symbol = '0;
	logic [PXW-1:0] price = '0;
	logic [QTYW-1:0] quantity = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STW-1:0] status;
	logic [TRDW-1:0] buy_trader, sell_trader;
	logic [SYMW-1:0] trade_symbol;
	logic [QTYW-1:0] trade_quantity;
	logic [PXW-1:0] trade_price;
	logic last;

	price_time_order_matcher_core u_top (.*);

	// book model
	logic            bk_valid [DEPTH];
	logic            bk_sell  [DEPTH];
	logic [TRDW-1:0] bk_trd   [DEPTH];
	logic [SYMW-1:0] bk_sym   [DEPTH];
	logic [PXW-1:0]  bk_px    [DEPTH];
	logic [QTYW-1:0] bk_rem   [DEPTH];
	logic [ARRW-1:0] bk_arr   [DEPTH];
	logic [ARRW-1:0] arrival_seq;

	order_beat_t order_q[$];
	fill_beat_t  fill_q[$];
	int errors = 0;
	int n_trades = 0, n_beats = 0, n_sent = 0;
	int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
	longint cycles = 0;

	// handshake seen at the last rising edge
	logic in_ready_s = 1'b0;

	// append a pending input beat
	task automatic queue_order(order_beat_t o);
		order_q.insert(order_q.size(), o);
	endtask

	// priority compare: a ahead of b
	function automatic bit ahead(int a, int b, bit hi_first);
		if (bk_px[a] != bk_px[b])
			return hi_first ? (bk_px[a] > bk_px[b]) : (bk_px[a] < bk_px[b]);
		if (bk_arr[a] != bk_arr[b])
			return bk_arr[a] < bk_arr[b];
		return a < b;
	endfunction

	function automatic fill_beat_t mk(logic [STW-1:0] s);
		fill_beat_t f;
		f = '0;
		f.st = s;
		return f;
	endfunction

	// advance book model for one accepted beat, queue the expected outputs
	task automatic book_apply(order_beat_t o);
		fill_beat_t f;
		bit done [DEPTH];
		int slot, b, s, n;
		logic [QTYW-1:0] q;
		if (o.op == OP_BUY || o.op == OP_SELL) begin
			if (o.qty == 0) begin
				f = mk(ST_ZERO);
			end else begin
				slot = -1;
				for (int i = 0; i < DEPTH; i++)
					if (slot < 0 && !bk_valid[i]) slot = i;
				if (slot < 0) begin
					f = mk(ST_FULL);
				end else begin
					bk_valid[slot] = 1'b1;
					bk_sell[slot] = (o.op == OP_SELL);
					bk_trd[slot] = o.trd;
					bk_sym[slot] = o.sym;
					bk_px[slot] = o.px;
					bk_rem[slot] = o.qty;
					bk_arr[slot] = arrival_seq;
					arrival_seq++;
					f = mk(ST_ACCEPTED);
				end
			end
			f.lst = 1'b1;
			fill_q.insert(fill_q.size(), f);
		end else if (o.op == OP_MATCH) begin
			n = 0;
			foreach (done[i]) done[i] = 0;
			forever begin
				b = -1;
				for (int i = 0; i < DEPTH; i++)
					if (bk_valid[i] && !bk_sell[i] && !done[i] && (b < 0 || ahead(i, b, 1)))
						b = i;
				if (b < 0) break;
				done[b] = 1;
				while (bk_valid[b] && n < MAX_RESULTS) begin
					s = -1;
					for (int i = 0; i < DEPTH; i++)
						if (bk_valid[i] && bk_sell[i] && bk_sym[i] == bk_sym[b] &&
						    bk_px[i] <= bk_px[b] && (s < 0 || ahead(i, s, 0)))
							s = i;
					if (s < 0) break;
					q = (bk_rem[b] < bk_rem[s]) ? bk_rem[b] : bk_rem[s];
					f = mk(ST_TRADE);
					f.bt = bk_trd[b];
					f.sl = bk_trd[s];
					f.sym = bk_sym[s];
					f.qty = q;
					f.px = bk_px[s];
					fill_q.insert(fill_q.size(), f);
					n++;
					n_trades++;
					bk_rem[b] -= q;
					bk_rem[s] -= q;
					if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
					if (bk_rem[s] == 0) bk_valid[s] = 1'b0;
				end
				if (n >= MAX_RESULTS) break;
			end
			if (n == 0) fill_q.insert(fill_q.size(), mk(ST_NO_TRADE));
			fill_q[$].lst = 1'b1;
		end
	endtask

	// clock and reset
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		foreach (bk_valid[i]) bk_valid[i] = 1'b0;
		arrival_seq = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: offers the oldest pending beat, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if ((!in_valid || in_ready_s) && order_q.size() > 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				opcode <= order_q[0].op;
				trader <= order_q[0].trd;
				symbol <= order_q[0].sym;
				price <= order_q[0].px;
				quantity <= order_q[0].qty;
				in_valid <= 1'b1;
				order_q.pop_front();
			end else if (in_valid && in_ready_s) begin
				in_valid <= 1'b0;
			end
			out_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// receiver hold-off countdown
	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
	end

	always @(posedge clk) begin
		in_ready_s <= 1'b0;
		cycles <= cycles + 1;
		if (in_valid && in_ready) begin
			in_ready_s <= 1'b1;
			n_sent <= n_sent + 1;
			book_apply(order_beat_t'{opcode, trader, symbol, price, quantity});
		end
	end

	// monitor: checks each output beat against the oldest expectation
	always @(posedge clk) begin
		fill_beat_t got, exp_b;
		if (out_valid && out_ready) begin
			got = '{status, buy_trader, sell_trader, trade_symbol, trade_quantity,
				trade_price, last};
			n_beats <= n_beats + 1;
			if (fill_q.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
			end else begin
				exp_b = fill_q.pop_front();
				if (got.st != exp_b.st) begin
					$display("%0t: status exp %0d got %0d", $time, exp_b.st, got.st);
					errors++;
				end
				if (got.bt != exp_b.bt) begin
					$display("%0t: buy_trader exp %0d got %0d", $time, exp_b.bt, got.bt);
					errors++;
				end
				if (got.sl != exp_b.sl) begin
					$display("%0t: sell_trader exp %0d got %0d", $time, exp_b.sl, got.sl);
					errors++;
				end
				if (got.sym != exp_b.sym) begin
					$display("%0t: trade_symbol exp %0d got %0d", $time, exp_b.sym, got.sym);
					errors++;
				end
				if (got.qty != exp_b.qty) begin
					$display("%0t: trade_quantity exp %0d got %0d", $time, exp_b.qty,
						got.qty);
					errors++;
				end
				if (got.px != exp_b.px) begin
					$display("%0t: trade_price exp %0d got %0d", $time, exp_b.px, got.px);
					errors++;
				end
				if (got.lst != exp_b.lst) begin
					$display("%0t: last exp %0d got %0d", $time, exp_b.lst, got.lst);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic order_beat_t ord(logic [OPW-1:0] op, logic [TRDW-1:0] t,
		logic [SYMW-1:0] s, logic [PXW-1:0] p, logic [QTYW-1:0] q);
		order_beat_t o;
		o = '{op, t, s, p, q};
		return o;
	endfunction

	// random beat: mostly adds on a few symbols with clustered prices
	function automatic order_beat_t rand_beat();
		order_beat_t o;
		int r;
		r = $urandom_range(99);
		o.trd = TRDW'($urandom());
		o.sym = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(2));
		o.px = ($urandom_range(9) == 0) ? $urandom() : 32'(100 + $urandom_range(8));
		case ($urandom_range(3))
			0: o.qty = QTYW'($urandom());
			default: o.qty = 31'($urandom_range(20));
		endcase
		if (r < 40) o.op = OP_BUY;
		else if (r < 80) o.op = OP_SELL;
		else if (r < 97) o.op = OP_MATCH;
		else o.op = OP_UNUSED;
		return o;
	endfunction

	task automatic drain();
		while (order_q.size() > 0 || in_valid || fill_q.size() > 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int phase_pct [4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{21, 21}};
		@(posedge arst_n);
		// directed: empty pass, zero qty, extremes, ties, full book, unused op
		queue_order(ord(OP_MATCH, 0, 0, 0, 0));
		queue_order(ord(OP_BUY, 5, 1, 50, 0));
		queue_order(ord(OP_SELL, 31'h7fff_ffff, 16'hffff, 32'hffff_ffff, 31'h7fff_ffff));
		queue_order(ord(OP_BUY, 0, 16'hffff, 32'hffff_ffff, 31'h7fff_ffff));
		queue_order(ord(OP_UNUSED, 1, 1, 1, 1));
		queue_order(ord(OP_MATCH, 0, 0, 0, 0));
		queue_order(ord(OP_SELL, 11, 7, 10, 5));
		queue_order(ord(OP_SELL, 12, 7, 10, 5));
		queue_order(ord(OP_SELL, 13, 7, 9, 3));
		queue_order(ord(OP_BUY, 21, 7, 10, 4));
		queue_order(ord(OP_BUY, 22, 7, 12, 8));
		queue_order(ord(OP_BUY, 23, 7, 8, 8));
		queue_order(ord(OP_MATCH, 0, 0, 0, 0));
		for (int i = 0; i < 17; i++)
			queue_order(ord(OP_BUY, 30 + i, 3, 0, 1));
		queue_order(ord(OP_SELL, 99, 3, 0, 0));
		queue_order(ord(OP_SELL, 98, 3, 0, 20));
		queue_order(ord(OP_MATCH, 0, 0, 0, 0));
		drain();
		// random phases with different idle mixes
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_pct[p][0];
			recv_stall_pct = phase_pct[p][1];
			for (int i = 0; i < 95; i++) queue_order(rand_beat());
			queue_order(ord(OP_MATCH, 0, 0, 0, 0));
			if (p == 1) begin
				// long receiver hold-off so the core backs up
				hold_cycles = 400;
				send_idle_pct = 0;
			end
			drain();
		end
		repeat (200) @(posedge clk);
		$display("sent %0d beats, checked %0d output beats, %0d trades", n_sent, n_beats,
			n_trades);
		if (errors == 0 && fill_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
